// ===== rtl/core/apm_pkg.sv =====
// ----------------------------------------------------------------------------
// Affine point map package
// Shared widths, register indexes, the divider cell payload and small
// arithmetic helpers for the affine point map unit.
// ----------------------------------------------------------------------------
package apm_pkg;

	// Fixed-point format of coefficients and coordinates.
	localparam int FRAC_BITS = 16;
	localparam int COEF_W    = 32;
	localparam int PROD_W    = 2 * COEF_W;
	// A sum of four products needs two guard bits.
	localparam int SUM_W     = PROD_W + 2;
	// Magnitude of the determinant fits in one product width.
	localparam int DMAG_W    = PROD_W;
	// Quotient magnitude bits produced by the cell chain.
	localparam int QBITS     = 34;
	// Remainder and shifted divisor width.
	localparam int REM_W     = DMAG_W + QBITS;

	// Configuration port.
	localparam int NREG   = 6;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_A = 3'd0;
	localparam logic [IDX_W-1:0] REG_B = 3'd1;
	localparam logic [IDX_W-1:0] REG_C = 3'd2;
	localparam logic [IDX_W-1:0] REG_D = 3'd3;
	localparam logic [IDX_W-1:0] REG_E = 3'd4;
	localparam logic [IDX_W-1:0] REG_F = 3'd5;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

	localparam logic OP_FWD = 1'b0;
	localparam logic OP_INV = 1'b1;

	localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] e;
		logic signed [COEF_W-1:0] f;
	} coef_t;

	// Payload handed from cell to cell along the divider chain.
	typedef struct packed {
		logic              op;
		logic              zdet;
		logic              negx;
		logic              negy;
		logic [COEF_W-1:0] fx;
		logic [COEF_W-1:0] fy;
		logic              fclip;
		logic [REM_W-1:0]  remx;
		logic [REM_W-1:0]  remy;
		logic [REM_W-1:0]  dsh;
		logic [QBITS-1:0]  qx;
		logic [QBITS-1:0]  qy;
	} cell_t;

	typedef struct packed {
		logic              clip;
		logic [COEF_W-1:0] val;
	} sat_t;

	// Exact signed 32 by 32 product.
	function automatic logic signed [PROD_W-1:0] smul(
		input logic signed [COEF_W-1:0] p,
		input logic signed [COEF_W-1:0] q
	);
		logic signed [PROD_W-1:0] r;
		r = PROD_W'(p) * PROD_W'(q);
		return r;
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
		sat_t r;
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[SUM_W-1:COEF_W-1];
		hi_zeros = ~|v[SUM_W-1:COEF_W-1];
		r.clip = !(hi_ones || hi_zeros);
		if (hi_ones || hi_zeros) begin
			r.val = v[COEF_W-1:0];
		end else if (v[SUM_W-1]) begin
			r.val = SAT_MIN;
		end else begin
			r.val = SAT_MAX;
		end
		return r;
	endfunction

	// Magnitude of a wide signed value.
	function automatic logic [SUM_W-1:0] absw(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		return r;
	endfunction

endpackage

// ===== rtl/core/apm_if.sv =====
// ----------------------------------------------------------------------------
// Affine point map channels
// Valid/ready channels for the point request and the mapped point response.
// ----------------------------------------------------------------------------
interface apm_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] x_in;
	logic signed [31:0] y_in;

	modport source (output valid, output op, output x_in, output y_in, input ready);
	modport sink   (input valid, input op, input x_in, input y_in, output ready);
endinterface

interface apm_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic               ok;
	logic               clipped;

	modport source (output valid, output x_out, output y_out, output ok, output clipped,
		input ready);
	modport sink   (input valid, input x_out, input y_out, input ok, input clipped,
		output ready);
endinterface

// ===== rtl/core/affine_point_map_forward_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// Affine point map, forward and inverse
// Maps points through a programmable 2x3 Q16.16 affine map or its inverse.
//
// Usage: program coef_a..coef_f over the APB port (byte address 4*i) while
// no points are in flight. Points enter on req (op, x_in, y_in) and leave on
// rsp (x_out, y_out, ok, clipped), one response per request, in order.
// The pipeline has four front stages (products, partial sums, full
// sums, magnitudes), a chain of 34 divider cells that each settle one
// quotient bit for both coordinates, and the output register. Forward
// requests ride the same pipeline so ordering is preserved.
// Throughput is one point per cycle while rsp does not stall; the divider chain is fully pipelined.
// When rsp stalls, each stage keeps accepting until it is full, so empty
// slots close up before req.ready drops.
// Reset clears all valid flags and loads the identity map.
// ----------------------------------------------------------------------------
module affine_point_map_forward_inverse_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	apm_req_if.sink                    req,
	apm_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [apm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import apm_pkg::*;

	coef_t coef;
	cell_t chain [QBITS+1];
	logic  vld   [QBITS+1];
	logic  rdy   [QBITS+1];

	cell_t             tail;
	logic              vld_q;
	logic              adv;
	logic [COEF_W-1:0] x_q, y_q;
	logic              ok_q, clip_q;
	sat_t              qsx, qsy;
	logic [COEF_W-1:0] xo, yo;
	logic              oko, clipo;

	apm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	apm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (coef),
		.req         (req),
		.chain_d     (chain[0]),
		.chain_valid (vld[0]),
		.chain_ready (rdy[0])
	);

	// Divider chain, most significant quotient bit first.
	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		apm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.d       (chain[i]),
			.d_valid (vld[i]),
			.d_ready (rdy[i]),
			.q       (chain[i+1]),
			.q_valid (vld[i+1]),
			.q_ready (rdy[i+1])
		);
	end

	assign tail       = chain[QBITS];
	assign adv        = !vld_q || rsp.ready;
	assign rdy[QBITS] = adv;

	// Signed quotient saturation.
	function automatic sat_t qsat(input logic [QBITS-1:0] m, input logic neg);
		sat_t r;
		logic big;
		big = neg ? (m > QBITS'(SAT_MIN)) : (m > QBITS'(SAT_MAX));
		r.clip = big;
		if (big) begin
			r.val = neg ? SAT_MIN : SAT_MAX;
		end else begin
			r.val = neg ? COEF_W'(-m[COEF_W-1:0]) : m[COEF_W-1:0];
		end
		return r;
	endfunction

	// Result selection by operation.
	always_comb begin
		qsx = qsat(tail.qx, tail.negx);
		qsy = qsat(tail.qy, tail.negy);
		if (tail.op == OP_FWD) begin
			xo    = tail.fx;
			yo    = tail.fy;
			oko   = 1'b1;
			clipo = tail.fclip;
		end else if (tail.zdet) begin
			xo    = '0;
			yo    = '0;
			oko   = 1'b0;
			clipo = 1'b0;
		end else begin
			xo    = qsx.val;
			yo    = qsy.val;
			oko   = 1'b1;
			clipo = qsx.clip || qsy.clip;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld[QBITS]) begin
			x_q    <= xo;
			y_q    <= yo;
			ok_q   <= oko;
			clip_q <= clipo;
		end
	end

	assign rsp.valid   = vld_q;
	assign rsp.x_out   = x_q;
	assign rsp.y_out   = y_q;
	assign rsp.ok      = ok_q;
	assign rsp.clipped = clip_q;

endmodule

// ===== rtl/core/apm_cfg.sv =====
// ----------------------------------------------------------------------------
// Affine point map coefficient registers
// APB-style register file holding the six Q16.16 map coefficients.
// ----------------------------------------------------------------------------
module apm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apm_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output apm_pkg::coef_t              coef
);
	import apm_pkg::*;

	coef_t            coef_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coef   = coef_q;

	// Register writes; indexes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a <= COEF_ONE;
			coef_q.b <= '0;
			coef_q.c <= '0;
			coef_q.d <= '0;
			coef_q.e <= COEF_ONE;
			coef_q.f <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_A:   coef_q.a <= pwdata;
				REG_B:   coef_q.b <= pwdata;
				REG_C:   coef_q.c <= pwdata;
				REG_D:   coef_q.d <= pwdata;
				REG_E:   coef_q.e <= pwdata;
				REG_F:   coef_q.f <= pwdata;
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (idx)
			REG_A:   prdata = coef_q.a;
			REG_B:   prdata = coef_q.b;
			REG_C:   prdata = coef_q.c;
			REG_D:   prdata = coef_q.d;
			REG_E:   prdata = coef_q.e;
			REG_F:   prdata = coef_q.f;
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/apm_front.sv =====
// ----------------------------------------------------------------------------
// Affine point map front end
// Four stages: products, partial sums, full sums, then forward saturation and
// the numerator and divisor magnitudes that seed the divider chain.
// ----------------------------------------------------------------------------
module apm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  apm_pkg::coef_t coef,
	apm_req_if.sink        req,
	output apm_pkg::cell_t chain_d,
	output logic           chain_valid,
	input  logic           chain_ready
);
	import apm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic                     op_s1;
	logic signed [PROD_W-1:0] ax_s1, dx_s1, ex_s1, by_s1, ey_s1, ay_s1;
	logic signed [PROD_W-1:0] ae_s1, bd_s1, bf_s1, ce_s1, cd_s1, af_s1;

	logic                     op_s2;
	logic signed [SUM_W-1:0]  fxa_s2, fya_s2, nxa_s2, nxb_s2, nya_s2, nyb_s2, det_s2;

	logic                     op_s3;
	logic signed [SUM_W-1:0]  fx_s3, fy_s3, nx_s3, ny_s3, det_s3;

	cell_t                    cell_s4;
	cell_t                    seed;
	sat_t                     sx, sy;
	logic signed [SUM_W-1:0]  shx, shy;
	logic [SUM_W-1:0]         mag_nx, mag_ny, mag_det;

	// Each stage moves on when it is empty or its successor moves.
	assign adv4      = !v_s4 || chain_ready;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 1: all coordinate and coefficient products.
	always_ff @(posedge clk) begin
		if (adv1 && req.valid) begin
			op_s1 <= req.op;
			ax_s1 <= smul(coef.a, req.x_in);
			dx_s1 <= smul(coef.d, req.x_in);
			ex_s1 <= smul(coef.e, req.x_in);
			by_s1 <= smul(coef.b, req.y_in);
			ey_s1 <= smul(coef.e, req.y_in);
			ay_s1 <= smul(coef.a, req.y_in);
			ae_s1 <= smul(coef.a, coef.e);
			bd_s1 <= smul(coef.b, coef.d);
			bf_s1 <= smul(coef.b, coef.f);
			ce_s1 <= smul(coef.c, coef.e);
			cd_s1 <= smul(coef.c, coef.d);
			af_s1 <= smul(coef.a, coef.f);
		end
	end

	// Stage 2: pairwise sums and the determinant.
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			op_s2  <= op_s1;
			fxa_s2 <= SUM_W'(ax_s1) + SUM_W'(by_s1);
			fya_s2 <= SUM_W'(dx_s1) + SUM_W'(ey_s1);
			nxa_s2 <= SUM_W'(ex_s1) - SUM_W'(by_s1);
			nxb_s2 <= SUM_W'(bf_s1) - SUM_W'(ce_s1);
			nya_s2 <= SUM_W'(ay_s1) - SUM_W'(dx_s1);
			nyb_s2 <= SUM_W'(cd_s1) - SUM_W'(af_s1);
			det_s2 <= SUM_W'(ae_s1) - SUM_W'(bd_s1);
		end
	end

	// Stage 3: offsets for the forward map, full inverse numerators.
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			op_s3  <= op_s2;
			fx_s3  <= fxa_s2 + (SUM_W'(coef.c) <<< FRAC_BITS);
			fy_s3  <= fya_s2 + (SUM_W'(coef.f) <<< FRAC_BITS);
			nx_s3  <= nxa_s2 + nxb_s2;
			ny_s3  <= nya_s2 + nyb_s2;
			det_s3 <= det_s2;
		end
	end

	// Stage 4: forward results and divider seed values.
	always_comb begin
		shx     = fx_s3 >>> FRAC_BITS;
		shy     = fy_s3 >>> FRAC_BITS;
		sx      = sat32(shx);
		sy      = sat32(shy);
		mag_nx  = absw(nx_s3);
		mag_ny  = absw(ny_s3);
		mag_det = absw(det_s3);

		seed.op    = op_s3;
		seed.zdet  = (det_s3 == '0);
		seed.negx  = nx_s3[SUM_W-1] ^ det_s3[SUM_W-1];
		seed.negy  = ny_s3[SUM_W-1] ^ det_s3[SUM_W-1];
		seed.fx    = sx.val;
		seed.fy    = sy.val;
		seed.fclip = sx.clip || sy.clip;
		seed.remx  = REM_W'(mag_nx) << FRAC_BITS;
		seed.remy  = REM_W'(mag_ny) << FRAC_BITS;
		seed.dsh   = REM_W'(mag_det[DMAG_W-1:0]) << (QBITS - 1);
		seed.qx    = '0;
		seed.qy    = '0;
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			cell_s4 <= seed;
		end
	end

	assign chain_d     = cell_s4;
	assign chain_valid = v_s4;

endmodule

// ===== rtl/core/apm_cell.sv =====
// ----------------------------------------------------------------------------
// Affine point map divider cell
// One restoring division step for the x and y quotients; the shifted divisor
// is halved on its way to the next cell.
// ----------------------------------------------------------------------------
module apm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  apm_pkg::cell_t d,
	input  logic           d_valid,
	output logic           d_ready,
	output apm_pkg::cell_t q,
	output logic           q_valid,
	input  logic           q_ready
);
	import apm_pkg::*;

	cell_t cell_q;
	cell_t nxt;
	logic  vld_q;
	logic  adv;
	logic  gex, gey;

	assign adv     = !vld_q || q_ready;
	assign d_ready = adv;

	// Compare and subtract on both lanes.
	always_comb begin
		gex      = d.remx >= d.dsh;
		gey      = d.remy >= d.dsh;
		nxt      = d;
		nxt.remx = gex ? d.remx - d.dsh : d.remx;
		nxt.remy = gey ? d.remy - d.dsh : d.remy;
		nxt.qx   = {d.qx[QBITS-2:0], gex};
		nxt.qy   = {d.qy[QBITS-2:0], gey};
		nxt.dsh  = d.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && d_valid) begin
			cell_q <= nxt;
		end
	end

	assign q       = cell_q;
	assign q_valid = vld_q;

endmodule
